/* design/ftq_pkg.sv */
// ----------------------------------------------------------------------------
// ftq_pkg
// Shared types and codes of the filtered track queue: command and filter
// codes, register indexes, payload structs, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ftq_pkg;

  // command codes carried in the kind field
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_TAKE       = 3'd2;
  localparam logic [2:0] KIND_CLEAR      = 3'd3;
  localparam logic [2:0] KIND_COUNT      = 3'd4;
  localparam logic [2:0] KIND_ADVANCE    = 3'd5;

  // count filter codes
  localparam logic [1:0] FILT_ALL    = 2'd0;
  localparam logic [1:0] FILT_STREAM = 2'd1;
  localparam logic [1:0] FILT_SOUND  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REUSE_WINDOW = 1'd1;

  localparam logic [15:0] REUSE_WINDOW_RESET = 16'd500;
  localparam logic [3:0]  COUNT_SAT          = 4'd15;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] track_id;
    logic        track_format;
    logic        speakers_only;
    logic        want_slot;
    logic        requester_is_speaker;
    logic [31:0] now_ms;
    logic [1:0]  count_filter;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] track_out;
    logic [3:0]  count_out;
  } out_item_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SHIFT_RD = 7'b0001000,
    S_SHIFT_WR = 7'b0010000,
    S_COMMIT   = 7'b0100000,
    S_DONE     = 7'b1000000
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_run;
    logic shift_wr;
    logic commit;
    logic emit;
  } ftq_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic hit_found;
    logic hit_zero;
    logic shift_last;
    logic out_free;
  } ftq_stat_t;

endpackage

/* design/ftq_ctrl.sv */
// ----------------------------------------------------------------------------
// ftq_ctrl
// Sequencer of the track queue: steps one command at a time through
// execute, entry scan, order-keeping shift, commit and result hand-off.
// ----------------------------------------------------------------------------
module ftq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ftq_pkg::ftq_stat_t stat,
  output ftq_pkg::ftq_cmd_t  cmd
);
  import ftq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          if (!stat.hit_found) begin
            state_nxt = S_DONE;
          end else if (stat.hit_zero) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = stat.shift_last ? S_COMMIT : S_SHIFT_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* design/ftq_dpath.sv */
// ----------------------------------------------------------------------------
// ftq_dpath
// Datapath of the track queue: entry memory with registered read, ring
// pointers, reuse-window state, scan and shift counters, result and
// output registers, configuration registers.
// ----------------------------------------------------------------------------
module ftq_dpath #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int TRACK_ID_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ftq_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ftq_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [ftq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ftq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ftq_pkg::ftq_cmd_t                  cmd,
  output ftq_pkg::ftq_stat_t                 stat
);
  import ftq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = TRACK_ID_WIDTH + 2;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);

  // offset from the head, wrapped into the ring
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [3:0] sat_count(input logic [CW-1:0] c);
    logic [7:0] w;
    w = 8'(c);
    return (w > 8'(COUNT_SAT)) ? COUNT_SAT : w[3:0];
  endfunction

  // entry memory: {track, format, speaker mark}
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [PW-1:0] mem_raddr, mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_we;

  in_item_t                  item_r, item_nxt;
  logic [PW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic [TRACK_ID_WIDTH-1:0] act_track_r, act_track_nxt;
  logic                      act_valid_r, act_valid_nxt;
  logic                      act_slot_r, act_slot_nxt;
  logic [31:0]               last_time_r, last_time_nxt;
  logic                      armed_r, armed_nxt;
  logic                      loop_r, loop_nxt;
  logic [15:0]               win_r, win_nxt;
  logic [CW-1:0]             scan_idx_r, scan_idx_nxt;
  logic                      pend_r, pend_nxt;
  logic [CW-1:0]             pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             sh_idx_r, sh_idx_nxt;
  logic [EW-1:0]             hit_entry_r, hit_entry_nxt;
  out_item_t                 res_r, res_nxt;
  out_item_t                 out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [31:0]               trk_wide;
  logic [TRACK_ID_WIDTH-1:0] trk_in;
  logic [31:0]               act_wide, hit_wide;
  logic [31:0]               elapsed;
  logic                      reuse_hit, is_take, filt_scan, full, issue;
  logic                      rd_fmt, rd_mark, take_match, want_fmt, scan_done;

  assign trk_wide   = {16'b0, item_r.track_id};
  assign trk_in     = trk_wide[TRACK_ID_WIDTH-1:0];
  assign act_wide   = 32'(act_track_r);
  assign hit_wide   = 32'(hit_entry_r[EW-1:2]);
  assign elapsed    = item_r.now_ms - last_time_r;
  assign reuse_hit  = armed_r && act_valid_r && (act_slot_r == item_r.want_slot) &&
                      (elapsed < {16'b0, win_r});
  assign is_take    = (item_r.kind == KIND_TAKE);
  assign filt_scan  = (item_r.count_filter == FILT_STREAM) ||
                      (item_r.count_filter == FILT_SOUND);
  assign full       = (fill_r == FULL_CNT);
  assign issue      = (scan_idx_r < fill_r);
  assign rd_fmt     = rd_data_r[1];
  assign rd_mark    = rd_data_r[0];
  assign want_fmt   = (item_r.count_filter == FILT_STREAM);
  assign take_match = (rd_fmt == item_r.want_slot) &&
                      !(rd_mark && !item_r.requester_is_speaker);
  assign scan_done  = (!pend_r && !issue) || (is_take && pend_r && take_match);

  assign stat.need_scan  = (is_take && !reuse_hit) ||
                           ((item_r.kind == KIND_COUNT) && filt_scan);
  assign stat.scan_done  = scan_done;
  assign stat.hit_found  = is_take && pend_r && take_match;
  assign stat.hit_zero   = (pend_idx_r == '0);
  assign stat.shift_last = (sh_idx_r == CW'(1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    item_nxt      = item_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    act_track_nxt = act_track_r;
    act_valid_nxt = act_valid_r;
    act_slot_nxt  = act_slot_r;
    last_time_nxt = last_time_r;
    armed_nxt     = armed_r;
    loop_nxt      = loop_r;
    win_nxt       = win_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    cnt_nxt       = cnt_r;
    sh_idx_nxt    = sh_idx_r;
    hit_entry_nxt = hit_entry_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = ring_pos(head_r, fill_r);
    mem_wdata     = {trk_in, item_r.track_format, item_r.speakers_only};
    mem_raddr     = cmd.scan_run ? ring_pos(head_r, scan_idx_r)
                                 : ring_pos(head_r, sh_idx_r - CW'(1));

    if (cfg_we) begin
      case (cfg_index)
        REG_LOOP_ENABLE:  loop_nxt = cfg_data[0];
        REG_REUSE_WINDOW: win_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load_item) begin
      item_nxt = in_data;
    end

    if (cmd.exec) begin
      res_nxt.ok        = 1'b1;
      res_nxt.track_out = '0;
      res_nxt.count_out = '0;
      scan_idx_nxt      = '0;
      pend_nxt          = 1'b0;
      cnt_nxt           = '0;
      case (item_r.kind)
        KIND_PUSH_BACK: begin
          res_nxt.ok = !full;
          if (!full) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + CW'(1);
          end
        end
        KIND_PUSH_FRONT: begin
          head_nxt  = (head_r == '0) ? LAST_POS : head_r - PW'(1);
          mem_we    = 1'b1;
          mem_waddr = head_nxt;
          if (!full) begin
            fill_nxt = fill_r + CW'(1);
          end
          armed_nxt = 1'b0;
        end
        KIND_TAKE: begin
          if (reuse_hit) begin
            res_nxt.track_out = act_wide[15:0];
          end
        end
        KIND_CLEAR: begin
          res_nxt.count_out = sat_count(fill_r);
          head_nxt          = '0;
          fill_nxt          = '0;
        end
        KIND_COUNT: begin
          if (!filt_scan) begin
            res_nxt.count_out = sat_count(fill_r);
          end
        end
        KIND_ADVANCE: begin
          armed_nxt     = 1'b0;
          act_valid_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd.scan_run) begin
      if (issue) begin
        scan_idx_nxt = scan_idx_r + CW'(1);
        pend_nxt     = 1'b1;
        pend_idx_nxt = scan_idx_r;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && !is_take && (rd_fmt == want_fmt)) begin
        cnt_nxt = cnt_r + CW'(1);
      end
      if (scan_done) begin
        if (is_take) begin
          if (pend_r && take_match) begin
            hit_entry_nxt = rd_data_r;
            sh_idx_nxt    = pend_idx_r;
          end else begin
            res_nxt.ok = 1'b0;
          end
        end else begin
          res_nxt.count_out = sat_count(cnt_r);
        end
      end
    end

    // move the earlier entry one place toward the taken one
    if (cmd.shift_wr) begin
      mem_we     = 1'b1;
      mem_waddr  = ring_pos(head_r, sh_idx_r);
      mem_wdata  = rd_data_r;
      sh_idx_nxt = sh_idx_r - CW'(1);
    end

    if (cmd.commit) begin
      head_nxt = (head_r == LAST_POS) ? '0 : head_r + PW'(1);
      if (loop_r) begin
        // the taken entry is written back as the new tail
        mem_we    = 1'b1;
        mem_waddr = ring_pos(head_r, fill_r);
        mem_wdata = hit_entry_r;
      end else begin
        fill_nxt = fill_r - CW'(1);
      end
      act_track_nxt     = hit_entry_r[EW-1:2];
      act_valid_nxt     = 1'b1;
      act_slot_nxt      = item_r.want_slot;
      last_time_nxt     = item_r.now_ms;
      armed_nxt         = 1'b1;
      res_nxt.ok        = 1'b1;
      res_nxt.track_out = hit_wide[15:0];
      res_nxt.count_out = '0;
    end

    if (cmd.emit && stat.out_free) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      act_track_r <= '0;
      act_valid_r <= 1'b0;
      act_slot_r  <= 1'b0;
      last_time_r <= '0;
      armed_r     <= 1'b0;
      loop_r      <= 1'b0;
      win_r       <= REUSE_WINDOW_RESET;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      cnt_r       <= '0;
      sh_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      act_track_r <= act_track_nxt;
      act_valid_r <= act_valid_nxt;
      act_slot_r  <= act_slot_nxt;
      last_time_r <= last_time_nxt;
      armed_r     <= armed_nxt;
      loop_r      <= loop_nxt;
      win_r       <= win_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      cnt_r       <= cnt_nxt;
      sh_idx_r    <= sh_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    hit_entry_r <= hit_entry_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

/* design/filtered_track_queue.sv */
// ----------------------------------------------------------------------------
// filtered_track_queue
// Ring queue of track handles with format tags and speaker marks; push,
// filtered take with reuse window and loop mode, clear, count, advance.
// ----------------------------------------------------------------------------
// flow: push, clear, unfiltered count, advance and a reuse take go from execute
//   straight to the result; a filtered count and a take miss scan every entry; a
//   take hitting entry h scans up to h, shifts the entries before it, then commits
// pacing: one command in work at a time, set by the scan and the shift loop over
//   the single-read entry memory (one entry a cycle scanned, each shifted entry
//   read and then written), plus the time a stalled result holds
// reset: synchronous active-low rst_n empties the queue; entry memory has
//   no clearing pass, reuse window resets to 500 ms, loop off
module filtered_track_queue #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int TRACK_ID_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ftq_pkg::in_item_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output ftq_pkg::out_item_t             out_data,
  // register writes, to be taken only while idle: the user must keep to it, the block does not enforce it
  input  logic                           cfg_we,
  input  logic [ftq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftq_pkg::*;

  // controller commands and datapath status
  ftq_cmd_t  cmd;
  ftq_stat_t stat;

  // one transaction at a time; the output register frees the result
  // side so a new command is taken while a result waits
  ftq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry memory, ring pointers, reuse window and result registers
  ftq_dpath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .TRACK_ID_WIDTH (TRACK_ID_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* design/ftq_checker.sv */
// ----------------------------------------------------------------------------
// ftq_port_checker
// Port-level checks of the track queue: result channel hold rules, one
// transaction in work at a time, result field consistency.
// ----------------------------------------------------------------------------
module ftq_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ftq_pkg::out_item_t out_data
);
  import ftq_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // accepted command blocks the next one
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // a new result only appears while a command is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a command in work");

  // a handed-out track comes with ok and no count
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.track_out == 16'd0) ||
                  (out_data.ok && (out_data.count_out == 4'd0)))
    else $error("inconsistent result fields");

endmodule

bind filtered_track_queue ftq_port_checker u_ftq_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
